@@ hw/rtl/sgfp_pkg.sv @@
// Shared widths, constants, types and the arctangent table for the force unit.
`timescale 1ns / 1ps
package sgfp_pkg;

    localparam int POS_W    = 32;   // signed Q16.16 position
    localparam int REG_W    = 32;   // config register and mass width
    localparam int AX_W     = 48;   // scaled distance component, Q32.16
    localparam int SQ_W     = 96;   // square of a component, numerator
    localparam int DEN_W    = 98;   // sum of three squares
    localparam int REM_W    = DEN_W + 1;
    localparam int FORCE_W  = 48;   // Q32.16 magnitude
    localparam int DIV_BITS = FORCE_W;
    localparam int ANG_W    = 16;
    localparam int COR_W    = AX_W + 3;
    localparam int Z_W      = 34;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 32;

    localparam logic [FORCE_W-1:0] FORCE_MAX = '1;

    typedef enum logic [1:0] {
        CFG_SCALE = 2'd0,
        CFG_GRAV  = 2'd1,
        CFG_SOFT  = 2'd2
    } t_cfg_idx;

    // atan(2^-i), 2^32 = 2*pi, rounded to nearest
    localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // one step of the restoring divider
    typedef struct packed {
        logic               valid;
        logic [REM_W-1:0]   rem;
        logic [DIV_BITS-1:0] num_lo;
        logic [DIV_BITS-1:0] quo;
        logic [DEN_W-1:0]   den;
        logic               sat;
        logic               zero;
    } t_div_data;

    // one step of the vectoring CORDIC
    typedef struct packed {
        logic signed [COR_W-1:0] x;
        logic signed [COR_W-1:0] y;
        logic signed [Z_W-1:0]   z;
        logic                    ax_zero;
        logic                    ay_zero;
        logic                    sx;
        logic                    sy;
    } t_cor_data;

endpackage

@@ hw/rtl/sgfp_div_cell.sv @@
// Restoring divider cell: one quotient bit per cell.
`timescale 1ns / 1ps
module sgfp_div_cell
    import sgfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_data i_d,
    output t_div_data o_d
);

    logic [REM_W-1:0] w_sh;
    logic [REM_W-1:0] w_diff;
    logic             w_ge;
    t_div_data        n_d;
    t_div_data        r_d;

    always_comb begin
        w_sh   = {i_d.rem[REM_W-2:0], i_d.num_lo[DIV_BITS-1]};
        w_ge   = (w_sh >= {1'b0, i_d.den});
        w_diff = w_sh - {1'b0, i_d.den};
        n_d        = i_d;
        n_d.rem    = w_ge ? w_diff : w_sh;
        n_d.num_lo = {i_d.num_lo[DIV_BITS-2:0], 1'b0};
        n_d.quo    = {i_d.quo[DIV_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else begin
            r_d.valid <= n_d.valid;
        end
        r_d.rem    <= n_d.rem;
        r_d.num_lo <= n_d.num_lo;
        r_d.quo    <= n_d.quo;
        r_d.den    <= n_d.den;
        r_d.sat    <= n_d.sat;
        r_d.zero   <= n_d.zero;
    end

    assign o_d = r_d;

endmodule

@@ hw/rtl/sgfp_cordic_cell.sv @@
// Vectoring CORDIC cell: one micro-rotation per cell.
`timescale 1ns / 1ps
module sgfp_cordic_cell
    import sgfp_pkg::*;
#(
    parameter int STEP = 0
)(
    input  logic      i_clk,
    input  t_cor_data i_d,
    output t_cor_data o_d
);

    localparam logic signed [Z_W-1:0] ATAN_I = Z_W'({2'b00, ATAN_TAB[STEP]});

    logic signed [COR_W-1:0] w_xs;
    logic signed [COR_W-1:0] w_ys;
    t_cor_data               n_d;
    t_cor_data               r_d;

    always_comb begin
        w_xs = i_d.x >>> STEP;
        w_ys = i_d.y >>> STEP;
        n_d  = i_d;
        if (!i_d.y[COR_W-1]) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + ATAN_I;
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - ATAN_I;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

@@ hw/rtl/softened_gravity_force_polar_unit.sv @@
// Top level: softened pairwise gravity force as magnitude and binary angle.
`timescale 1ns / 1ps
// One item (two bodies) is taken every cycle in which start is high; busy is
// always low, so items may follow back to back without gaps. Each item gives
// exactly one result, marked by o_valid for a single cycle. It comes
// out of the 48-cell restoring divider that forms the Q32.16 quotient, behind
// six stages of differences, split multiplies and sums; the CORDIC angle
// chain (CORDIC_STAGES cells, at most 32) runs alongside and is delayed to
// meet it. The receiver cannot stall the unit, so
// results must be taken as they appear. Config registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data and must only change while no item is in
// flight; an index of 3 is ignored.
module softened_gravity_force_polar_unit
    import sgfp_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [POS_W-1:0] i_first_x,
    input  logic signed [POS_W-1:0] i_first_y,
    input  logic [REG_W-1:0]        i_first_mass,
    input  logic signed [POS_W-1:0] i_second_x,
    input  logic signed [POS_W-1:0] i_second_y,
    input  logic [REG_W-1:0]        i_second_mass,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [REG_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic [FORCE_W-1:0]      o_force_magnitude,
    output logic [ANG_W-1:0]        o_direction_angle,
    output logic                    o_coincident,
    output logic                    o_saturated
);

    // stages above 32 have zero arctangent and are not built
    localparam int CS      = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
    // divider's last cell lands at stage 6 + DIV_BITS; angle reg sits at 3 + CS
    localparam int ANG_DLY = 6 + DIV_BITS - 3 - CS + 1;

    assign busy = 1'b0;

    // ---------------- config registers ----------------
    logic [REG_W-1:0] r_scale, r_grav, r_soft;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= REG_W'(65536);
            r_grav  <= REG_W'(65536);
            r_soft  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE: r_scale <= i_cfg_data;
                CFG_GRAV:  r_grav  <= i_cfg_data;
                CFG_SOFT:  r_soft  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // ---------------- stage 1: differences and magnitudes ----------------
    logic [POS_W:0]   w_dx, w_dy;
    logic [POS_W-1:0] w_mx, w_my;

    always_comb begin
        w_dx = {i_second_x[POS_W-1], i_second_x} - {i_first_x[POS_W-1], i_first_x};
        w_dy = {i_second_y[POS_W-1], i_second_y} - {i_first_y[POS_W-1], i_first_y};
        w_mx = w_dx[POS_W] ? POS_W'(-w_dx) : w_dx[POS_W-1:0];
        w_my = w_dy[POS_W] ? POS_W'(-w_dy) : w_dy[POS_W-1:0];
    end

    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [POS_W-1:0] r_mx, r_my;
    logic             r_sx1, r_sy1, r_sx2, r_sy2;
    logic [REG_W-1:0] r_m1, r_m2_1, r_m2_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx   <= w_mx;
        r_my   <= w_my;
        r_sx1  <= w_dx[POS_W];
        r_sy1  <= w_dy[POS_W];
        r_m1   <= i_first_mass;
        r_m2_1 <= i_second_mass;
    end

    // ---------------- stage 2: scale, G*m1, eps^2 ----------------
    logic [63:0]     w_axp, w_ayp;
    logic [AX_W-1:0] r_ax, r_ay;
    logic [63:0]     r_gm, r_eps2_2;

    assign w_axp = 64'(r_mx) * 64'(r_scale);
    assign w_ayp = 64'(r_my) * 64'(r_scale);

    always_ff @(posedge i_clk) begin
        r_ax     <= w_axp[AX_W+15:16];
        r_ay     <= w_ayp[AX_W+15:16];
        r_gm     <= 64'(r_m1) * 64'(r_grav);
        r_eps2_2 <= 64'(r_soft) * 64'(r_soft);
        r_m2_2   <= r_m2_1;
        r_sx2    <= r_sx1;
        r_sy2    <= r_sy1;
    end

    // ---------------- stage 3: partial products ----------------
    logic [63:0] r_xll, r_yll, r_gl, r_gh, r_eps2_3;
    logic [47:0] r_xhl, r_yhl;
    logic [31:0] r_xhh, r_yhh;

    always_ff @(posedge i_clk) begin
        r_xll    <= 64'(r_ax[31:0]) * 64'(r_ax[31:0]);
        r_xhl    <= 48'(r_ax[AX_W-1:32]) * 48'(r_ax[31:0]);
        r_xhh    <= 32'(r_ax[AX_W-1:32]) * 32'(r_ax[AX_W-1:32]);
        r_yll    <= 64'(r_ay[31:0]) * 64'(r_ay[31:0]);
        r_yhl    <= 48'(r_ay[AX_W-1:32]) * 48'(r_ay[31:0]);
        r_yhh    <= 32'(r_ay[AX_W-1:32]) * 32'(r_ay[AX_W-1:32]);
        r_gl     <= 64'(r_gm[31:0]) * 64'(r_m2_2);
        r_gh     <= 64'(r_gm[63:32]) * 64'(r_m2_2);
        r_eps2_3 <= r_eps2_2;
    end

    // ---------------- stage 4: squares and numerator ----------------
    logic [SQ_W-1:0] r_ax2, r_ay2, r_num4, r_num5;
    logic [63:0]     r_eps2_4;

    always_ff @(posedge i_clk) begin
        r_ax2    <= SQ_W'(r_xll) + (SQ_W'(r_xhl) << 33) + (SQ_W'(r_xhh) << 64);
        r_ay2    <= SQ_W'(r_yll) + (SQ_W'(r_yhl) << 33) + (SQ_W'(r_yhh) << 64);
        r_num4   <= SQ_W'(r_gl) + (SQ_W'(r_gh) << 32);
        r_eps2_4 <= r_eps2_3;
    end

    // ---------------- stage 5: denominator ----------------
    logic [DEN_W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        r_den  <= DEN_W'(r_ax2) + DEN_W'(r_ay2) + DEN_W'(r_eps2_4);
        r_num5 <= r_num4;
    end

    // ---------------- stage 6: overflow check, divider load ----------------
    // quotient >= 2^48 exactly when the upper half of num reaches den
    t_div_data r_p6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6.valid <= 1'b0;
        end else begin
            r_p6.valid <= r_v5;
        end
        r_p6.rem    <= REM_W'(r_num5[SQ_W-1:DIV_BITS]);
        r_p6.num_lo <= r_num5[DIV_BITS-1:0];
        r_p6.quo    <= '0;
        r_p6.den    <= r_den;
        r_p6.sat    <= (DEN_W'(r_num5[SQ_W-1:DIV_BITS]) >= r_den);
        r_p6.zero   <= (r_den == '0);
    end

    // ---------------- divider chain ----------------
    t_div_data w_div [DIV_BITS+1];

    assign w_div[0] = r_p6;

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        sgfp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_div[k]),
            .o_d     (w_div[k+1])
        );
    end

    // ---------------- CORDIC chain (from stage 2) ----------------
    t_cor_data w_cor [CS+1];

    always_comb begin
        w_cor[0].x       = $signed(COR_W'(r_ay));
        w_cor[0].y       = $signed(COR_W'(r_ax));
        w_cor[0].z       = '0;
        w_cor[0].ax_zero = (r_ax == '0);
        w_cor[0].ay_zero = (r_ay == '0);
        w_cor[0].sx      = r_sx2;
        w_cor[0].sy      = r_sy2;
    end

    for (genvar k = 0; k < CS; k++) begin : g_cor
        sgfp_cordic_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_d   (w_cor[k]),
            .o_d   (w_cor[k+1])
        );
    end

    // first-quadrant angle, clamped to [0, pi/2], rounded, then to quadrant
    t_cor_data        w_cf;
    logic [30:0]      w_zc;
    logic [30:0]      w_zr;
    logic [ANG_W-1:0] w_theta, n_ang;

    always_comb begin
        w_cf = w_cor[CS];
        if (w_cf.z[Z_W-1]) begin
            w_zc = '0;
        end else if (w_cf.z > Z_W'(32'h40000000)) begin
            w_zc = 31'h40000000;
        end else begin
            w_zc = w_cf.z[30:0];
        end
        w_zr = w_zc + 31'h8000;
        if (w_cf.ax_zero) begin
            w_theta = '0;
        end else if (w_cf.ay_zero) begin
            w_theta = ANG_W'(16384);
        end else begin
            w_theta = ANG_W'(w_zr[30:16]);
        end
        if (w_cf.ax_zero && w_cf.ay_zero) begin
            n_ang = '0;
        end else if (!w_cf.sx && !w_cf.sy) begin
            n_ang = w_theta;
        end else if (!w_cf.sx) begin
            n_ang = ANG_W'(32768) - w_theta;
        end else if (w_cf.sy) begin
            n_ang = ANG_W'(32768) + w_theta;
        end else begin
            n_ang = ANG_W'(0) - w_theta;
        end
    end

    // angle delay line to meet the divider output
    logic [ANG_W-1:0] r_ang_dly [ANG_DLY];

    always_ff @(posedge i_clk) begin
        r_ang_dly[0] <= n_ang;
        for (int k = 1; k < ANG_DLY; k++) begin
            r_ang_dly[k] <= r_ang_dly[k-1];
        end
    end

    // ---------------- output register ----------------
    t_div_data w_last;

    assign w_last = w_div[DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.zero) begin
            o_force_magnitude <= '0;
        end else if (w_last.sat) begin
            o_force_magnitude <= FORCE_MAX;
        end else begin
            o_force_magnitude <= w_last.quo;
        end
        o_direction_angle <= r_ang_dly[ANG_DLY-1];
        o_coincident      <= w_last.zero;
        o_saturated       <= w_last.sat && !w_last.zero;
    end

endmodule

@@ tb/sv/softened_gravity_force_polar_unit_tb.sv @@
// Testbench for the softened gravity force unit: random and directed body pairs.
`timescale 1ns / 1ps
// Pairs of bodies go in through start/busy and are predicted at the accepting
// edge by a bit-exact model of the force (wide exact products, truncating
// divide, saturation) and the vectoring CORDIC angle. Results come out on
// o_valid with no back-pressure and are compared in order. The config
// registers are rewritten between phases, only once every result is back.
module softened_gravity_force_polar_unit_tb;
    import sgfp_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // index that the unit ignores
    localparam int         FLUSH_CYC  = 70;     // idle clocks after the last result is back
    localparam int         NUM_PHASES = 6;

    typedef struct {
        logic signed [POS_W-1:0] fx, fy, sx, sy;
        logic [REG_W-1:0]        fm, sm;
    } t_pair;

    typedef struct {
        logic [FORCE_W-1:0] mag;
        logic [ANG_W-1:0]   ang;
        logic               coin;
        logic               sat;
    } t_force;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [POS_W-1:0] i_first_x = '0, i_first_y = '0;
    logic signed [POS_W-1:0] i_second_x = '0, i_second_y = '0;
    logic [REG_W-1:0] i_first_mass = '0, i_second_mass = '0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_SCALE;
    logic [REG_W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic [FORCE_W-1:0] o_force_magnitude;
    logic [ANG_W-1:0] o_direction_angle;
    logic o_coincident, o_saturated;

    // model copy of the config registers
    logic [REG_W-1:0] scale_reg = 32'd65536;
    logic [REG_W-1:0] grav_reg  = 32'd65536;
    logic [REG_W-1:0] soft_reg  = '0;

    t_pair  pair_pending [$];
    t_force force_expected [$];
    t_pair  cur_pair;
    int     gap_left = 0;
    bit     no_gaps = 0;
    int     err_count = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     sat_seen = 0;
    int     coin_seen = 0;

    always #6 i_clk = ~i_clk;

    softened_gravity_force_polar_unit DUT (.*);

    // Predict one result from a pair and the current registers.
    function automatic t_force predict_force(t_pair p);
        t_force r;
        longint dx, dy, x, y, z, xs, ys;
        logic [63:0] mx, my, ax, ay;
        logic [127:0] den, num, quo;
        int theta, ang;
        dx = longint'(p.sx) - longint'(p.fx);
        dy = longint'(p.sy) - longint'(p.fy);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        ax = (mx * {32'd0, scale_reg}) >> 16;
        ay = (my * {32'd0, scale_reg}) >> 16;
        r = '{default: '0};
        if (ax == 0 && ay == 0 && soft_reg == 0) begin
            r.coin = 1'b1;
            return r;
        end
        den = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay)
            + 128'(soft_reg) * 128'(soft_reg);
        num = 128'(grav_reg) * 128'(p.fm) * 128'(p.sm);
        quo = num / den;
        if (quo > 128'(FORCE_MAX)) begin
            r.mag = FORCE_MAX;
            r.sat = 1'b1;
        end else begin
            r.mag = quo[FORCE_W-1:0];
        end
        if (ax == 0 && ay == 0) begin
            ang = 0;
        end else begin
            // first-quadrant angle from +Y, axes handled exactly
            if (ax == 0) begin
                theta = 0;
            end else if (ay == 0) begin
                theta = 16384;
            end else begin
                x = longint'(ay);
                y = longint'(ax);
                z = 0;
                for (int i = 0; i < CORDIC_STAGES_DEF && i < CORDIC_MAX; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0) begin
                        x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
                    end else begin
                        x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
                    end
                end
                if (z < 0) z = 0;
                if (z > 64'h4000_0000) z = 64'h4000_0000;
                theta = int'((z + 64'h8000) >> 16);
            end
            if (dx >= 0 && dy >= 0) ang = theta;
            else if (dx >= 0)      ang = 32768 - theta;
            else if (dy < 0)       ang = 32768 + theta;
            else                   ang = 65536 - theta;
        end
        r.ang = ang[ANG_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Driver: accept on start && !busy, then load the next item after a random gap, if any.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                force_expected.push_back(predict_force(cur_pair));
                items_sent++;
            end
            if (start && busy) begin
                start <= 1'b1;  // hold the item until it is taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pair_pending.size() > 0) begin
                cur_pair = pair_pending.pop_front();
                i_first_x <= cur_pair.fx;
                i_first_y <= cur_pair.fy;
                i_first_mass <= cur_pair.fm;
                i_second_x <= cur_pair.sx;
                i_second_y <= cur_pair.sy;
                i_second_mass <= cur_pair.sm;
                start <= 1'b1;
                if (no_gaps || $urandom_range(0, 9) < 6) gap_left <= 0;
                else if ($urandom_range(0, 9) < 8) gap_left <= $urandom_range(1, 3);
                else gap_left <= $urandom_range(10, 40);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        t_force e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (force_expected.size() == 0) begin
                report_mismatch("unexpected result", o_force_magnitude, 0);
            end else begin
                e = force_expected.pop_front();
                if (e.sat) sat_seen++;
                if (e.coin) coin_seen++;
                if (o_force_magnitude !== e.mag)
                    report_mismatch("force_magnitude", o_force_magnitude, e.mag);
                if (o_direction_angle !== e.ang)
                    report_mismatch("direction_angle", o_direction_angle, e.ang);
                if (o_coincident !== e.coin)
                    report_mismatch("coincident", o_coincident, e.coin);
                if (o_saturated !== e.sat)
                    report_mismatch("saturated", o_saturated, e.sat);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0003_FFFF);
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h8000_0000;
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    // Second coordinate: far, near, equal, a fresh pick_word value or a random offset above.
    function automatic logic [31:0] pick_partner(logic [31:0] a);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1, 2: return a + ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            3: return a;
            4: return pick_word();
            default: return a + ($urandom() >> $urandom_range(8, 31));
        endcase
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        p.fx = pick_word();
        p.fy = pick_word();
        p.sx = pick_partner(p.fx);
        p.sy = pick_partner(p.fy);
        p.fm = ($urandom_range(0, 3) == 0) ? pick_word() : $urandom_range(0, 32'h00FF_FFFF);
        p.sm = ($urandom_range(0, 3) == 0) ? pick_word() : $urandom_range(0, 32'h00FF_FFFF);
        return p;
    endfunction

    function automatic t_pair mk(int fx, int fy, int fm, int sx, int sy, int sm);
        t_pair p;
        p.fx = fx; p.fy = fy; p.fm = fm; p.sx = sx; p.sy = sy; p.sm = sm;
        return p;
    endfunction

    // Directed pairs: coincidence, each axis direction, extremes.
    task automatic load_directed();
        pair_pending.push_back(mk(0, 0, 32'h10000, 0, 0, 32'h10000));
        pair_pending.push_back(mk(123, -7, -1, 123, -7, -1));
        pair_pending.push_back(mk(0, 0, 32'h10000, 0, 32'h10000, 32'h10000));
        pair_pending.push_back(mk(0, 0, 32'h10000, 0, -32'h10000, 32'h10000));
        pair_pending.push_back(mk(0, 0, 32'h10000, 32'h10000, 0, 32'h10000));
        pair_pending.push_back(mk(0, 0, 32'h10000, -32'h10000, 0, 32'h10000));
        pair_pending.push_back(mk(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
        pair_pending.push_back(mk(0, 0, 32'h10000, 32'h10000, -32'h10000, 32'h10000));
        pair_pending.push_back(mk(0, 0, 32'h10000, -32'h10000, -32'h10000, 32'h10000));
        pair_pending.push_back(mk(0, 0, 32'h10000, -32'h10000, 32'h10000, 32'h10000));
        pair_pending.push_back(mk(32'h8000_0000, 32'h8000_0000, -1,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, -1));
        pair_pending.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 0,
                                  32'h8000_0000, 32'h7FFF_FFFF, -1));
        pair_pending.push_back(mk(0, 0, -1, 1, 0, -1));
        pair_pending.push_back(mk(0, 0, -1, 0, 1, -1));
        pair_pending.push_back(mk(5, 9, 0, 3, 2, 0));
        pair_pending.push_back(mk(0, 0, 32'h10000, 1, 2, 32'h10000));
        pair_pending.push_back(mk(-1, -1, 32'h30000, 32'h0123_4567, -32'h0765_4321, 32'h50000));
        pair_pending.push_back(mk(0, 0, 32'hFFFF, 32'h7FFF_FFFF, 1, 32'hFFFF));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SCALE: scale_reg = data;
            CFG_GRAV:  grav_reg  = data;
            CFG_SOFT:  soft_reg  = data;
            default: ;  // ignored by the unit
        endcase
    endtask

    // Hold off until the driver is empty and every result is back.
    task automatic wait_drained();
        while (pair_pending.size() > 0 || start || force_expected.size() > 0)
            @(posedge i_clk);
        repeat (FLUSH_CYC) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;  // reset values
                1: begin
                    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
                    write_reg(CFG_GRAV, 32'hFFFF_FFFF);
                    write_reg(CFG_SOFT, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(CFG_SCALE, 32'd0);
                    write_reg(CFG_GRAV, 32'd1);
                    write_reg(CFG_SOFT, 32'd0);
                end
                3: begin
                    write_reg(CFG_SCALE, 32'd65536);
                    write_reg(CFG_GRAV, 32'd65536);
                    write_reg(CFG_SOFT, 32'h0001_8000);
                    write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
                end
                4: begin
                    write_reg(CFG_SCALE, $urandom_range(1, 32'h0004_0000));
                    write_reg(CFG_GRAV, $urandom());
                    write_reg(CFG_SOFT, $urandom() >> $urandom_range(0, 31));
                end
                default: begin
                    write_reg(CFG_SCALE, $urandom() >> $urandom_range(0, 31));
                    write_reg(CFG_GRAV, $urandom_range(0, 32'h000F_FFFF));
                    write_reg(CFG_SOFT, 32'd0);
                end
            endcase
            no_gaps = (ph == 3);
            if (ph == 0 || ph == 3) load_directed();
            for (int n = 0; n < 110; n++) pair_pending.push_back(random_pair());
            wait_drained();
        end
        $display("covered %0d pairs over %0d register settings", items_sent, NUM_PHASES);
        $display("results: %0d, saturated: %0d, coincident: %0d",
                 results_seen, sat_seen, coin_seen);
        if (err_count == 0) begin
            $display("softened_gravity_force_polar_unit: match");
        end else begin
            $display("softened_gravity_force_polar_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("softened_gravity_force_polar_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sgfp_pkg.sv
hw/rtl/sgfp_div_cell.sv
hw/rtl/sgfp_cordic_cell.sv
hw/rtl/softened_gravity_force_polar_unit.sv
tb/sv/softened_gravity_force_polar_unit_tb.sv
